// ===== rtl/core/drive_path_syntax_checker_assert.svh =====
// Assertion macros for the drive path syntax checker.
// Used by drive_path_syntax_checker.sv; needs no other file.
`ifndef DRIVE_PATH_SYNTAX_CHECKER_ASSERT_SVH
`define DRIVE_PATH_SYNTAX_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define DPSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("drive path checker assertion failed");
`define DPSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("drive path checker assertion failed");
`else
`define DPSC_ASSERT(lbl, clk, rst_n, prop)
`define DPSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/dpsc_pkg.sv =====
// Shared types and constants of the drive path syntax checker.
// Used by dpsc_parser and drive_path_syntax_checker; depends on nothing.
`default_nettype none
package dpsc_pkg;

  localparam int MAX_DEPTH  = 64;
  localparam int MAX_NAME   = 255;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT  = 1'b1;

  localparam logic [6:0] DEPTH_LIMIT_RST = 7'd64;
  localparam logic [7:0] NAME_LIMIT_RST  = 8'd255;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic REC_DIR = 1'b0;
  localparam logic REC_SUM = 1'b1;

  typedef enum logic [2:0] {
    PH_DRIVE0 = 3'd0,
    PH_DRIVE1 = 3'd1,
    PH_COLON  = 3'd2,
    PH_SLASH  = 3'd3,
    PH_NAMES  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_NO_COLON = 3'd2,
    ERR_NO_SLASH = 3'd3,
    ERR_EMPTY    = 3'd4,
    ERR_DEEP     = 3'd5,
    ERR_LONG     = 3'd6,
    ERR_BAD_CHAR = 3'd7
  } err_t;

  typedef struct packed {
    logic       record_kind;
    logic [5:0] dir_index;
    logic [7:0] dir_name_length;
    logic       path_ok;
    logic [2:0] error_code;
    logic       is_directory;
    logic [6:0] dir_total;
    logic [7:0] file_length;
    logic [7:0] stem_length;
    logic       has_extension;
    logic [7:0] drive_first;
    logic [7:0] drive_second;
  } record_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    record_t rec0;
    record_t rec1;
  } rec_push_t;

  function automatic logic name_char(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], CH_UNDER, CH_DOT};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/drive_path_syntax_checker.sv =====
// Drive path syntax checker, top level: parser and a three-entry result queue.
// Depends on dpsc_pkg, dpsc_parser and drive_path_syntax_checker_assert.svh.
//
// Path bytes arrive on the in_ channel, one byte per accepted word, with
// in_last_char high on the final byte. Results leave on the out_ channel.
// A slash that closes a directory name yields a directory record; the final
// byte yields a summary record, so the final byte of a path that ends in a
// closed directory yields two records, the directory record first.
// One byte is accepted per cycle while in_stall is low; each byte is checked
// by combinational parser logic between the path state registers and the
// queue, and its records are registered into the queue as it is accepted.
// The queue holds up to three records and in_stall rises while two or more
// are held, so a receiver that stalls fills it and then stops the input.
// The depth and name limits are written through cfg_we, cfg_addr and cfg_wdata;
// the user writes them only while the block is idle, which it does not enforce.
// Reset empties the queue, sets the limits to 64 levels and 255 characters
// and starts a fresh path.
`default_nettype none
`include "drive_path_syntax_checker_assert.svh"
module drive_path_syntax_checker import dpsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_char_in,
  input  wire logic                  in_last_char,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_record_kind,
  output logic [5:0]                 out_dir_index,
  output logic [7:0]                 out_dir_name_length,
  output logic                       out_path_ok,
  output logic [2:0]                 out_error_code,
  output logic                       out_is_directory,
  output logic [6:0]                 out_dir_total,
  output logic [7:0]                 out_file_length,
  output logic [7:0]                 out_stem_length,
  output logic                       out_has_extension,
  output logic [7:0]                 out_drive_first,
  output logic [7:0]                 out_drive_second
);

  localparam int QD = 3;

  logic      acc, pop;
  rec_push_t push;
  record_t   q_r [QD];
  record_t   q_nxt [QD];
  logic [1:0] cnt_r, cnt_nxt, base;

  assign in_stall  = (cnt_r >= 2'd2);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  dpsc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .char_in   (in_char_in),
    .last_char (in_last_char),
    .push      (push)
  );

  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < QD; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QD - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < QD; i++) begin
      if (push.push0 && base == 2'(i)) q_nxt[i] = push.rec0;
      if (push.push1 && base + 2'd1 == 2'(i)) q_nxt[i] = push.rec1;
    end
    cnt_nxt = base + {1'b0, push.push0} + {1'b0, push.push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_record_kind     = q_r[0].record_kind;
  assign out_dir_index       = q_r[0].dir_index;
  assign out_dir_name_length = q_r[0].dir_name_length;
  assign out_path_ok         = q_r[0].path_ok;
  assign out_error_code      = q_r[0].error_code;
  assign out_is_directory    = q_r[0].is_directory;
  assign out_dir_total       = q_r[0].dir_total;
  assign out_file_length     = q_r[0].file_length;
  assign out_stem_length     = q_r[0].stem_length;
  assign out_has_extension   = q_r[0].has_extension;
  assign out_drive_first     = q_r[0].drive_first;
  assign out_drive_second    = q_r[0].drive_second;

  `DPSC_ASSERT(a_room_on_accept, clk, rst_n, acc |-> cnt_r <= 2'd1)
  `DPSC_ASSERT_NEXT(a_two_records, clk, rst_n, push.push1 && !pop, cnt_r == $past(cnt_r) + 2'd2)
  `DPSC_ASSERT(a_sum_ok_flag, clk, rst_n,
      out_valid && out_record_kind == REC_SUM |-> out_path_ok == (out_error_code == ERR_OK))
  `DPSC_ASSERT(a_dir_nonempty, clk, rst_n,
      out_valid && out_record_kind == REC_DIR |-> out_dir_name_length != 8'd0)

endmodule
`default_nettype wire

// ===== rtl/core/dpsc_parser.sv =====
// Path parser: configuration registers, per-path state and record building.
// Depends on dpsc_pkg.
`default_nettype none
module dpsc_parser import dpsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  acc,
  input  wire logic [7:0]            char_in,
  input  wire logic                  last_char,
  output rec_push_t                  push
);

  logic [6:0] depth_limit_r;
  logic [7:0] name_limit_r;
  phase_t     phase_r, phase_nxt, phase_u;
  err_t       err_r, err_nxt, err_u, err_sum;
  logic [7:0] drv0_r, drv0_nxt, drv0_u;
  logic [7:0] drv1_r, drv1_nxt, drv1_u;
  logic [6:0] dcnt_r, dcnt_nxt, dcnt_u;
  logic [7:0] nlen_r, nlen_nxt, nlen_u;
  logic [7:0] ldot_r, ldot_nxt, ldot_u;
  logic       dot_r, dot_nxt, dot_u;
  logic       dir_fire;
  logic [6:0] eff_depth;
  logic [7:0] eff_name;
  record_t    dir_rec, sum_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_limit_r <= DEPTH_LIMIT_RST;
      name_limit_r  <= NAME_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEPTH_LIMIT: depth_limit_r <= cfg_wdata[6:0];
        CFG_NAME_LIMIT:  name_limit_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign eff_depth = (32'(depth_limit_r) > MAX_DEPTH) ? 7'(MAX_DEPTH) : depth_limit_r;
  assign eff_name  = (32'(name_limit_r) > MAX_NAME) ? 8'(MAX_NAME) : name_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DRIVE0;
      err_r   <= ERR_OK;
      drv0_r  <= '0;
      drv1_r  <= '0;
      dcnt_r  <= '0;
      nlen_r  <= '0;
      ldot_r  <= '0;
      dot_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      drv0_r  <= drv0_nxt;
      drv1_r  <= drv1_nxt;
      dcnt_r  <= dcnt_nxt;
      nlen_r  <= nlen_nxt;
      ldot_r  <= ldot_nxt;
      dot_r   <= dot_nxt;
    end
  end

  always_comb begin
    phase_u  = phase_r;
    err_u    = err_r;
    drv0_u   = drv0_r;
    drv1_u   = drv1_r;
    dcnt_u   = dcnt_r;
    nlen_u   = nlen_r;
    ldot_u   = ldot_r;
    dot_u    = dot_r;
    dir_fire = 1'b0;
    if (acc && err_r == ERR_OK) begin
      case (phase_r)
        PH_DRIVE0: begin
          drv0_u  = char_in;
          phase_u = PH_DRIVE1;
        end
        PH_DRIVE1: begin
          drv1_u  = char_in;
          phase_u = PH_COLON;
        end
        PH_COLON: begin
          if (char_in == CH_COLON) phase_u = PH_SLASH;
          else err_u = ERR_NO_COLON;
        end
        PH_SLASH: begin
          if (char_in == CH_SLASH) phase_u = PH_NAMES;
          else err_u = ERR_NO_SLASH;
        end
        default: begin
          if (char_in == CH_SLASH) begin
            if (nlen_r == '0) begin
              err_u = ERR_EMPTY;
            end else if (dcnt_r >= eff_depth) begin
              err_u = ERR_DEEP;
            end else begin
              dir_fire = 1'b1;
              dcnt_u   = dcnt_r + 7'd1;
              nlen_u   = '0;
              ldot_u   = '0;
              dot_u    = 1'b0;
            end
          end else if (nlen_r >= eff_name) begin
            err_u = ERR_LONG;
          end else if (!name_char(char_in)) begin
            err_u = ERR_BAD_CHAR;
          end else begin
            if (char_in == CH_DOT) begin
              dot_u  = 1'b1;
              ldot_u = nlen_r;
            end
            nlen_u = nlen_r + 8'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    err_sum = err_u;
    if (err_u == ERR_OK) begin
      case (phase_u)
        PH_DRIVE1: err_sum = ERR_SHORT;
        PH_COLON:  err_sum = ERR_NO_COLON;
        PH_SLASH:  err_sum = ERR_NO_SLASH;
        default:   err_sum = ERR_OK;
      endcase
    end

    dir_rec                 = '0;
    dir_rec.record_kind     = REC_DIR;
    dir_rec.dir_index       = dcnt_r[5:0];
    dir_rec.dir_name_length = nlen_r;

    sum_rec              = '0;
    sum_rec.record_kind  = REC_SUM;
    sum_rec.error_code   = err_sum;
    sum_rec.drive_first  = drv0_u;
    sum_rec.drive_second = drv1_u;
    if (err_sum == ERR_OK) begin
      sum_rec.path_ok      = 1'b1;
      sum_rec.is_directory = (char_in == CH_SLASH);
      sum_rec.dir_total    = dcnt_u;
      if (char_in != CH_SLASH) begin
        sum_rec.file_length   = nlen_u;
        sum_rec.stem_length   = dot_u ? ldot_u : nlen_u;
        sum_rec.has_extension = dot_u;
      end
    end

    push.push0 = acc && (dir_fire || last_char);
    push.push1 = acc && dir_fire && last_char;
    push.rec0  = dir_fire ? dir_rec : sum_rec;
    push.rec1  = sum_rec;
  end

  always_comb begin
    if (acc && last_char) begin
      phase_nxt = PH_DRIVE0;
      err_nxt   = ERR_OK;
      drv0_nxt  = '0;
      drv1_nxt  = '0;
      dcnt_nxt  = '0;
      nlen_nxt  = '0;
      ldot_nxt  = '0;
      dot_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_u;
      err_nxt   = err_u;
      drv0_nxt  = drv0_u;
      drv1_nxt  = drv1_u;
      dcnt_nxt  = dcnt_u;
      nlen_nxt  = nlen_u;
      ldot_nxt  = ldot_u;
      dot_nxt   = dot_u;
    end
  end

endmodule
`default_nettype wire

// ===== bench/drive_path_syntax_checker_tb.sv =====
// Self-checking testbench for drive_path_syntax_checker: directed and random path strings
// under several depth and name limits, with random idling on the input and random output stalls.
// Depends on dpsc_pkg and the drive_path_syntax_checker RTL.
module drive_path_syntax_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpsc_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } path_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_in = 8'h41;
  logic                  in_last_char = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_record_kind;
  logic [5:0]            out_dir_index;
  logic [7:0]            out_dir_name_length;
  logic                  out_path_ok;
  logic [2:0]            out_error_code;
  logic                  out_is_directory;
  logic [6:0]            out_dir_total;
  logic [7:0]            out_file_length;
  logic [7:0]            out_stem_length;
  logic                  out_has_extension;
  logic [7:0]            out_drive_first;
  logic [7:0]            out_drive_second;

  drive_path_syntax_checker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_in          (in_char_in),
    .in_last_char        (in_last_char),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_kind     (out_record_kind),
    .out_dir_index       (out_dir_index),
    .out_dir_name_length (out_dir_name_length),
    .out_path_ok         (out_path_ok),
    .out_error_code      (out_error_code),
    .out_is_directory    (out_is_directory),
    .out_dir_total       (out_dir_total),
    .out_file_length     (out_file_length),
    .out_stem_length     (out_stem_length),
    .out_has_extension   (out_has_extension),
    .out_drive_first     (out_drive_first),
    .out_drive_second    (out_drive_second)
  );

  always #5 clk = ~clk;

  path_byte_t pending_bytes[$];
  record_t    due_records[$];

  logic [6:0] depth_reg = DEPTH_LIMIT_RST;
  logic [7:0] name_reg = NAME_LIMIT_RST;
  phase_t     parse_phase = PH_DRIVE0;
  err_t       first_error = ERR_OK;
  logic [7:0] drive_sym0 = '0;
  logic [7:0] drive_sym1 = '0;
  int         level_count = 0;
  int         name_len = 0;
  int         dot_pos = 0;
  bit         dot_found = 1'b0;

  bit word_taken = 1'b0;
  bit no_idle = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_requested = 0;
  int holds_started = 0;
  int mismatches = 0;
  int dir_records = 0;
  int summary_records = 0;
  int codes_seen[8];

  function automatic int depth_eff();
    return (depth_reg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_reg);
  endfunction

  function automatic int name_eff();
    return (name_reg > MAX_NAME) ? MAX_NAME : int'(name_reg);
  endfunction

  function automatic bit is_name_byte(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DOT;
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_DRIVE0;
    first_error = ERR_OK;
    drive_sym0 = '0;
    drive_sym1 = '0;
    level_count = 0;
    name_len = 0;
    dot_pos = 0;
    dot_found = 1'b0;
  endfunction

  // Advances the path state by one byte and queues the records it yields.
  function automatic void parse_path_byte(logic [7:0] ch, logic last);
    record_t rec;
    err_t    err;
    if (first_error == ERR_OK) begin
      case (parse_phase)
        PH_DRIVE0: begin
          drive_sym0 = ch;
          parse_phase = PH_DRIVE1;
        end
        PH_DRIVE1: begin
          drive_sym1 = ch;
          parse_phase = PH_COLON;
        end
        PH_COLON: begin
          if (ch == CH_COLON) parse_phase = PH_SLASH;
          else first_error = ERR_NO_COLON;
        end
        PH_SLASH: begin
          if (ch == CH_SLASH) parse_phase = PH_NAMES;
          else first_error = ERR_NO_SLASH;
        end
        default: begin
          if (ch == CH_SLASH) begin
            if (name_len == 0) begin
              first_error = ERR_EMPTY;
            end else if (level_count >= depth_eff()) begin
              first_error = ERR_DEEP;
            end else begin
              rec = '0;
              rec.record_kind = REC_DIR;
              rec.dir_index = level_count[5:0];
              rec.dir_name_length = name_len[7:0];
              due_records.push_back(rec);
              level_count++;
              name_len = 0;
              dot_pos = 0;
              dot_found = 1'b0;
            end
          end else if (name_len >= name_eff()) begin
            first_error = ERR_LONG;
          end else if (!is_name_byte(ch)) begin
            first_error = ERR_BAD_CHAR;
          end else begin
            if (ch == CH_DOT) begin
              dot_found = 1'b1;
              dot_pos = name_len;
            end
            name_len++;
          end
        end
      endcase
    end
    if (last) begin
      err = first_error;
      if (err == ERR_OK) begin
        case (parse_phase)
          PH_DRIVE1: err = ERR_SHORT;
          PH_COLON:  err = ERR_NO_COLON;
          PH_SLASH:  err = ERR_NO_SLASH;
          default:   err = ERR_OK;
        endcase
      end
      rec = '0;
      rec.record_kind = REC_SUM;
      rec.error_code = err;
      rec.drive_first = drive_sym0;
      rec.drive_second = drive_sym1;
      if (err == ERR_OK) begin
        rec.path_ok = 1'b1;
        rec.is_directory = (ch == CH_SLASH);
        rec.dir_total = level_count[6:0];
        if (ch != CH_SLASH) begin
          rec.file_length = name_len[7:0];
          rec.stem_length = dot_found ? dot_pos[7:0] : name_len[7:0];
          rec.has_extension = dot_found;
        end
      end
      due_records.push_back(rec);
      clear_parse();
    end
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    record_t got;
    record_t want;
    word_taken = rst_n && in_valid && !in_stall;
    if (word_taken) parse_path_byte(in_char_in, in_last_char);
    if (rst_n && out_valid && !out_stall) begin
      got = {out_record_kind, out_dir_index, out_dir_name_length, out_path_ok,
             out_error_code, out_is_directory, out_dir_total, out_file_length,
             out_stem_length, out_has_extension, out_drive_first, out_drive_second};
      if (due_records.size() == 0) begin
        $error("record with no expectation waiting: %h", got);
        mismatches++;
      end else begin
        want = due_records.pop_front();
        check_field("record_kind", want.record_kind, got.record_kind);
        check_field("dir_index", want.dir_index, got.dir_index);
        check_field("dir_name_length", want.dir_name_length, got.dir_name_length);
        check_field("path_ok", want.path_ok, got.path_ok);
        check_field("error_code", want.error_code, got.error_code);
        check_field("is_directory", want.is_directory, got.is_directory);
        check_field("dir_total", want.dir_total, got.dir_total);
        check_field("file_length", want.file_length, got.file_length);
        check_field("stem_length", want.stem_length, got.stem_length);
        check_field("has_extension", want.has_extension, got.has_extension);
        check_field("drive_first", want.drive_first, got.drive_first);
        check_field("drive_second", want.drive_second, got.drive_second);
        if (want.record_kind == REC_SUM) begin
          summary_records++;
          codes_seen[want.error_code]++;
        end else begin
          dir_records++;
        end
      end
    end
  end

  always @(negedge clk) begin
    path_byte_t nxt;
    logic       v_n;
    logic [7:0] c_n;
    logic       l_n;
    v_n = in_valid;
    c_n = in_char_in;
    l_n = in_last_char;
    if (!rst_n) begin
      v_n = 1'b0;
    end else begin
      if (in_valid && word_taken) begin
        v_n = 1'b0;
        if (!no_idle && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
      end
      if (!v_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          v_n = 1'b1;
          c_n = nxt.ch;
          l_n = nxt.last;
        end
      end
    end
    in_valid <= v_n;
    in_char_in <= c_n;
    in_last_char <= l_n;
  end

  // The receiver stalls in short random bursts, and for a long stretch on request.
  always @(negedge clk) begin
    logic s_n;
    if (holds_started < holds_requested) begin
      holds_started++;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      s_n = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      s_n = 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      s_n = 1'b1;
    end else begin
      s_n = 1'b0;
    end
    out_stall <= s_n;
  end

  function automatic void queue_path(byte_q_t b);
    path_byte_t pb;
    foreach (b[i]) begin
      pb.ch = b[i];
      pb.last = (i == b.size() - 1);
      pending_bytes.push_back(pb);
    end
  endfunction

  function automatic byte_q_t text_bytes(string s);
    byte_q_t b;
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    return b;
  endfunction

  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(0, 63);
    if ($urandom_range(0, 7) == 0) return CH_DOT;
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return CH_UNDER;
    return CH_DOT;
  endfunction

  function automatic void add_name(ref byte_q_t b, input int len);
    for (int i = 0; i < len; i++) b.push_back(pick_name_char());
  endfunction

  function automatic int pick_name_len();
    int lim;
    int r;
    lim = name_eff();
    if (lim == 0) return $urandom_range(1, 3);
    r = $urandom_range(0, 19);
    if (r == 0) return lim + 1;
    if (r == 1) return lim;
    return $urandom_range(1, (lim < 6) ? lim : 6);
  endfunction

  // Mostly well-formed paths with random content; the rest are noise,
  // truncated paths, a corrupted byte or an extra slash.
  function automatic int queue_random_path();
    byte_q_t b;
    int      style;
    int      n_dirs;
    int      cut;
    int      deep;
    style = $urandom_range(0, 9);
    b.push_back(8'($urandom_range(1, 255)));
    b.push_back(8'($urandom_range(1, 255)));
    if (style == 0) begin
      repeat ($urandom_range(0, 5)) b.push_back(8'($urandom_range(1, 255)));
    end else begin
      b.push_back(CH_COLON);
      b.push_back(CH_SLASH);
      deep = depth_eff();
      n_dirs = $urandom_range(0, (deep < 4) ? deep : 4);
      if (deep <= 8 && $urandom_range(0, 9) == 0) n_dirs = deep + 1;
      repeat (n_dirs) begin
        add_name(b, pick_name_len());
        b.push_back(CH_SLASH);
      end
      if ($urandom_range(0, 2) != 0) add_name(b, pick_name_len());
      if (style == 1) begin
        cut = $urandom_range(1, b.size());
        while (b.size() > cut) void'(b.pop_back());
      end else if (style == 2) begin
        b[$urandom_range(2, b.size() - 1)] = 8'($urandom_range(1, 255));
      end else if (style == 3) begin
        b.insert($urandom_range(4, b.size()), CH_SLASH);
      end
    end
    queue_path(b);
    return b.size();
  endfunction

  task automatic queue_random(input int byte_budget);
    int queued;
    queued = 0;
    while (queued < byte_budget) queued += queue_random_path();
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEPTH_LIMIT) depth_reg = val[6:0];
    else name_reg = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || due_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    byte_q_t b;
    foreach (codes_seen[i]) codes_seen[i] = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_path(text_bytes("C:/dir/file.txt"));
    queue_path(text_bytes("C:/"));
    queue_path(text_bytes("D:/a/bb/"));
    queue_path(text_bytes("Q"));
    queue_path(text_bytes("QR"));
    queue_path(text_bytes("QR:"));
    queue_path(text_bytes("QRx/a"));
    queue_path(text_bytes("QR:x"));
    queue_path(text_bytes("C://"));
    queue_path(text_bytes("C:/a$b/c"));
    queue_path(text_bytes("C:/bad-"));
    queue_path(text_bytes("C:/ab/.x"));
    queue_path(text_bytes("C:/a.b.c"));
    queue_path(text_bytes("C:/x."));
    b = {8'hFF, 8'h01, CH_COLON, CH_SLASH, CH_UNDER, "9"};
    queue_path(b);
    b = text_bytes("C:/");
    add_name(b, MAX_NAME);
    b.push_back(CH_SLASH);
    add_name(b, MAX_NAME);
    queue_path(b);
    b = text_bytes("C:/");
    add_name(b, MAX_NAME + 1);
    queue_path(b);
    b = text_bytes("C:/");
    repeat (MAX_DEPTH) b = {b, "d", CH_SLASH};
    b.push_back("f");
    queue_path(b);
    b = text_bytes("C:/");
    repeat (MAX_DEPTH + 1) b = {b, "d", CH_SLASH};
    b.push_back("f");
    queue_path(b);
    queue_random(200);
    holds_requested++;
    wait_drained();

    write_limit(CFG_DEPTH_LIMIT, 8'd1);
    write_limit(CFG_NAME_LIMIT, 8'd1);
    queue_random(100);
    wait_drained();

    write_limit(CFG_DEPTH_LIMIT, 8'd0);
    write_limit(CFG_NAME_LIMIT, 8'd255);
    queue_path(text_bytes("C:/"));
    queue_path(text_bytes("C:/a/"));
    queue_random(80);
    wait_drained();

    write_limit(CFG_DEPTH_LIMIT, 8'hFF);
    write_limit(CFG_NAME_LIMIT, 8'd0);
    queue_path(text_bytes("C:/a"));
    queue_random(80);
    holds_requested++;
    wait_drained();

    write_limit(CFG_DEPTH_LIMIT, 8'd5);
    write_limit(CFG_NAME_LIMIT, 8'd8);
    queue_random(150);
    wait_drained();

    no_idle = 1'b1;
    write_limit(CFG_DEPTH_LIMIT, 8'd64);
    write_limit(CFG_NAME_LIMIT, 8'd12);
    queue_random(150);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d directory records and %0d path summaries under six limit settings.",
             dir_records, summary_records);
    $display("Summaries per error code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             codes_seen[0], codes_seen[1], codes_seen[2], codes_seen[3],
             codes_seen[4], codes_seen[5], codes_seen[6], codes_seen[7]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Run timed out with %0d records still expected.", due_records.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
